@@ sv/quaternion_vector_rotation_assert.svh @@
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_assert.svh
// assertion macros for the quaternion rotation pipeline
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATION_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATION_ASSERT_SVH

// same-cycle implication, quiet during reset
`define QVR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define QVR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked in reset as well
`define QVR_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/qvr_pkg.sv @@
// ----------------------------------------------------------------------------
// qvr_pkg
// widths, rounding constants and types for the quaternion rotation pipeline
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int QUAT_BITS = 16;
    localparam int VEC_BITS  = 24;
    localparam int QFRAC     = QUAT_BITS - 2;

    localparam int PROD1_W = QUAT_BITS + VEC_BITS;
    localparam int SUM1_W  = PROD1_W + 2;
    localparam int T_W     = VEC_BITS + 3;
    localparam int PROD2_W = T_W + QUAT_BITS;
    localparam int SUM2_W  = PROD2_W + 2;
    localparam int RES_W   = SUM2_W - QFRAC;

    typedef logic signed [QUAT_BITS-1:0] t_quat;
    typedef logic signed [VEC_BITS-1:0]  t_vec;
    typedef logic signed [PROD1_W-1:0]   t_prod1;
    typedef logic signed [SUM1_W-1:0]    t_sum1;
    typedef logic signed [T_W-1:0]       t_mid;
    typedef logic signed [PROD2_W-1:0]   t_prod2;
    typedef logic signed [SUM2_W-1:0]    t_sum2;
    typedef logic signed [RES_W-1:0]     t_res;

    localparam t_sum1 RND1 = SUM1_W'(1) << (QFRAC - 1);
    localparam t_sum2 RND2 = SUM2_W'(1) << (QFRAC - 1);

    localparam t_vec VEC_MAX = {1'b0, {(VEC_BITS-1){1'b1}}};
    localparam t_vec VEC_MIN = {1'b1, {(VEC_BITS-1){1'b0}}};

endpackage

@@ sv/quaternion_vector_rotation.sv @@
// data path: an accepted input beat passes the stage 1 to stage 4 registers to its output beat
// throughput: one beat per cycle while i_stall is low, set by the four-stage multiply/add pipeline
// each stage holds its beat when the next one is full and held, bubbles are squeezed out
// reset: synchronous active-low i_rst_n clears all stage valid bits
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// rotates a 3-vector by q * (0,v) * conj(q) in fixed point, saturated output
// ----------------------------------------------------------------------------
module quaternion_vector_rotation
    import qvr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_quat i_quat_w,
    input  t_quat i_quat_x,
    input  t_quat i_quat_y,
    input  t_quat i_quat_z,
    input  t_vec  i_vec_x,
    input  t_vec  i_vec_y,
    input  t_vec  i_vec_z,
    output logic  o_valid,
    input  logic  i_stall,
    output t_vec  o_rot_x,
    output t_vec  o_rot_y,
    output t_vec  o_rot_z
);

`include "quaternion_vector_rotation_assert.svh"

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    t_prod1 r_p1 [12];
    t_quat  r_q1 [4];
    t_sum1  s1_sum [4];
    t_mid   n_t [4];
    t_mid   r_t [4];
    t_quat  r_q2 [4];
    t_prod2 r_p3 [12];
    t_sum2  s3_sum [3];
    t_res   s3_res [3];
    t_vec   n_rot [3];
    t_vec   r_rot [3];

    assign en4 = !r_v4 || !i_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_stall = !en1;
    assign o_valid = r_v4;
    assign o_rot_x = r_rot[0];
    assign o_rot_y = r_rot[1];
    assign o_rot_z = r_rot[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // stage 1: q * v products
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_p1[0]  <= PROD1_W'(i_quat_x) * PROD1_W'(i_vec_x);
            r_p1[1]  <= PROD1_W'(i_quat_y) * PROD1_W'(i_vec_y);
            r_p1[2]  <= PROD1_W'(i_quat_z) * PROD1_W'(i_vec_z);
            r_p1[3]  <= PROD1_W'(i_quat_w) * PROD1_W'(i_vec_x);
            r_p1[4]  <= PROD1_W'(i_quat_y) * PROD1_W'(i_vec_z);
            r_p1[5]  <= PROD1_W'(i_quat_z) * PROD1_W'(i_vec_y);
            r_p1[6]  <= PROD1_W'(i_quat_w) * PROD1_W'(i_vec_y);
            r_p1[7]  <= PROD1_W'(i_quat_z) * PROD1_W'(i_vec_x);
            r_p1[8]  <= PROD1_W'(i_quat_x) * PROD1_W'(i_vec_z);
            r_p1[9]  <= PROD1_W'(i_quat_w) * PROD1_W'(i_vec_z);
            r_p1[10] <= PROD1_W'(i_quat_x) * PROD1_W'(i_vec_y);
            r_p1[11] <= PROD1_W'(i_quat_y) * PROD1_W'(i_vec_x);
            r_q1[0]  <= i_quat_w;
            r_q1[1]  <= i_quat_x;
            r_q1[2]  <= i_quat_y;
            r_q1[3]  <= i_quat_z;
        end
    end

    // stage 2: first product sums, round half up
    always_comb begin
        s1_sum[0] = RND1 - SUM1_W'(r_p1[0]) - SUM1_W'(r_p1[1]) - SUM1_W'(r_p1[2]);
        for (int i = 1; i < 4; i++) begin
            s1_sum[i] = RND1 + SUM1_W'(r_p1[3*i]) + SUM1_W'(r_p1[3*i+1])
                      - SUM1_W'(r_p1[3*i+2]);
        end
        for (int i = 0; i < 4; i++) begin
            n_t[i] = s1_sum[i][QFRAC+T_W-1:QFRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_t  <= n_t;
            r_q2 <= r_q1;
        end
    end

    // stage 3: t * conj(q) products
    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_p3[0]  <= PROD2_W'(r_t[1]) * PROD2_W'(r_q2[0]);
            r_p3[1]  <= PROD2_W'(r_t[0]) * PROD2_W'(r_q2[1]);
            r_p3[2]  <= PROD2_W'(r_t[2]) * PROD2_W'(r_q2[3]);
            r_p3[3]  <= PROD2_W'(r_t[3]) * PROD2_W'(r_q2[2]);
            r_p3[4]  <= PROD2_W'(r_t[2]) * PROD2_W'(r_q2[0]);
            r_p3[5]  <= PROD2_W'(r_t[0]) * PROD2_W'(r_q2[2]);
            r_p3[6]  <= PROD2_W'(r_t[3]) * PROD2_W'(r_q2[1]);
            r_p3[7]  <= PROD2_W'(r_t[1]) * PROD2_W'(r_q2[3]);
            r_p3[8]  <= PROD2_W'(r_t[3]) * PROD2_W'(r_q2[0]);
            r_p3[9]  <= PROD2_W'(r_t[0]) * PROD2_W'(r_q2[3]);
            r_p3[10] <= PROD2_W'(r_t[1]) * PROD2_W'(r_q2[2]);
            r_p3[11] <= PROD2_W'(r_t[2]) * PROD2_W'(r_q2[1]);
        end
    end

    // stage 4: second sums, round, saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s3_sum[i] = RND2 + SUM2_W'(r_p3[4*i]) - SUM2_W'(r_p3[4*i+1])
                      - SUM2_W'(r_p3[4*i+2]) + SUM2_W'(r_p3[4*i+3]);
            s3_res[i] = s3_sum[i][SUM2_W-1:QFRAC];
            if (&s3_res[i][RES_W-1:VEC_BITS-1] || ~|s3_res[i][RES_W-1:VEC_BITS-1]) begin
                n_rot[i] = s3_res[i][VEC_BITS-1:0];
            end else if (s3_res[i][RES_W-1]) begin
                n_rot[i] = VEC_MIN;
            end else begin
                n_rot[i] = VEC_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_v3) begin
            r_rot <= n_rot;
        end
    end

    `QVR_ASSERT_IMP(a_stall_full, o_stall, r_v1 && r_v2 && r_v3 && r_v4, "stall with a free stage")
    `QVR_ASSERT_NEXT(a_out_kept, o_valid && i_stall, o_valid, "output beat lost under stall")
    `QVR_ASSERT_RST(a_rst_empty, !i_rst_n, !o_valid && !o_stall, "pipeline not empty after reset")

endmodule
